// File: sv/spc_pkg.sv
// ----------------------------------------------------------------------------
// Shutter position controller package
// Shared types, codes and constants for the controller, the datapath and the
// top level.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam logic [7:0]  PRESCALE_RESET = 8'd20;
    localparam logic [3:0]  PULSE_RESET    = 4'd3;
    localparam logic [6:0]  FULL_POS       = 7'd100;
    localparam logic [6:0]  RUN_FACTOR     = 7'd11;
    // floor(x / 10) = (x * 6554) >> 16 and floor(x / 100) = (x * 5243) >> 19
    // hold over the ranges of products that occur here.
    localparam logic [12:0] RECIP_10       = 13'd6554;
    localparam logic [12:0] RECIP_100      = 13'd5243;
    localparam int          SHIFT_10       = 16;
    localparam int          SHIFT_100      = 19;
    localparam logic [3:0]  DIV_STEPS      = 4'd15;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_SET    = 3'd1,
        CMD_UP     = 3'd2,
        CMD_DOWN   = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_INVERT = 3'd5,
        CMD_TOGGLE = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_STILL = 2'd0,
        DIR_UP    = 2'd1,
        DIR_DOWN  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        KIND_RELAY  = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_BUSY   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_TRAVEL   = 2'd0,
        REG_IMPULSE  = 2'd1,
        REG_PRESCALE = 2'd2,
        REG_PULSE    = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BUSY_ERR,
        ST_STOP,
        ST_MUL1,
        ST_MUL2,
        ST_APPLY,
        ST_REPORT,
        ST_TICK,
        ST_UPC,
        ST_DNC,
        ST_MOVE,
        ST_DIV,
        ST_POS,
        ST_NEXT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DECODE,
        OP_BUSY_ERR,
        OP_STOP,
        OP_MUL1,
        OP_MUL2,
        OP_APPLY,
        OP_REPORT,
        OP_PRESCALE,
        OP_UPC,
        OP_DNC,
        OP_MOVE,
        OP_DIV,
        OP_POS,
        OP_NEXT,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic [63:0] travel;
        logic [7:0]  impulse;
        logic [7:0]  prescale;
        logic [3:0]  plen;
    } cfg_t;

    typedef struct packed {
        logic is_tick;
        logic cmd_ok;
        logic moving;
        logic cmd_set;
        logic cmd_stop;
        logic step_hit;
        logic mc_nz;
        logic div_last;
        logic last_ch;
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] unit;
        logic       relay;
        logic       drive_on;
        logic [6:0] pos;
    } result_t;

endpackage

// File: sv/spc_ctrl.sv
// ----------------------------------------------------------------------------
// Shutter controller sequencer
// Walks one item through decode, then a stop, a busy refusal, the set-position
// arithmetic or per-channel control step, issuing one datapath op per cycle.
// ----------------------------------------------------------------------------
module spc_ctrl
    import spc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output op_t     op,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_tick)
                begin
                    state_next = ST_TICK;
                end
                else if (!status.cmd_ok)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.moving && status.cmd_set)
                begin
                    state_next = ST_BUSY_ERR;
                end
                else if (status.moving || status.cmd_stop)
                begin
                    state_next = ST_STOP;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_BUSY_ERR: state_next = ST_FINISH;
            ST_STOP:     state_next = ST_FINISH;
            ST_MUL1:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_APPLY;
            ST_APPLY:    state_next = ST_REPORT;
            ST_REPORT:   state_next = ST_FINISH;
            ST_TICK:     state_next = status.step_hit ? ST_UPC : ST_FINISH;
            ST_UPC:      state_next = ST_DNC;
            ST_DNC:      state_next = ST_MOVE;
            ST_MOVE:     state_next = status.mc_nz ? ST_DIV : ST_NEXT;
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:      state_next = ST_NEXT;
            ST_NEXT:     state_next = status.last_ch ? ST_FINISH : ST_UPC;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:     op = start ? OP_LATCH : OP_NONE;
            ST_DECODE:   op = OP_DECODE;
            ST_BUSY_ERR: op = OP_BUSY_ERR;
            ST_STOP:     op = OP_STOP;
            ST_MUL1:     op = OP_MUL1;
            ST_MUL2:     op = OP_MUL2;
            ST_APPLY:    op = OP_APPLY;
            ST_REPORT:   op = OP_REPORT;
            ST_TICK:     op = OP_PRESCALE;
            ST_UPC:      op = OP_UPC;
            ST_DNC:      op = OP_DNC;
            ST_MOVE:     op = OP_MOVE;
            ST_DIV:      op = OP_DIV;
            ST_POS:      op = OP_POS;
            ST_NEXT:     op = OP_NEXT;
            ST_FINISH:   op = OP_FINISH;
            default:     op = OP_NONE;
        endcase
    end

endmodule

// File: sv/spc_datapath.sv
// ----------------------------------------------------------------------------
// Shutter controller datapath
// Per-channel state, prescaler, set-position multipliers, the serial divider
// for position estimation and the result staging registers.
// ----------------------------------------------------------------------------
module spc_datapath
    import spc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  logic [2:0] command_in,
    input  logic [2:0] channel_in,
    input  logic [6:0] target_in,
    input  cfg_t       cfg,
    output status_t    status,
    output logic       res_valid,
    output logic       res_last,
    output result_t    res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [2:0]        cmd_reg;
    logic [2:0]        ch_reg;
    logic [6:0]        tgt_reg;
    logic [6:0]        eff_reg;
    logic [6:0]        pos_reg  [CHANNELS];
    logic [6:0]        goal_reg [CHANNELS];
    logic [7:0]        mc_reg   [CHANNELS];
    dir_t              dir_reg  [CHANNELS];
    logic              tog_reg  [CHANNELS];
    logic signed [4:0] upc_reg  [CHANNELS];
    logic signed [4:0] dnc_reg  [CHANNELS];
    logic [7:0]        pres_reg;
    logic [14:0]       prod_reg;
    logic [8:0]        q_reg;
    logic [14:0]       num_reg;
    logic [7:0]        rem_reg;
    logic [3:0]        dcnt_reg;
    logic              pend_valid_reg;
    result_t           pend_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    result_t           out_reg;

    logic [IDX_W-1:0]  idx;
    logic              ch_ok;
    logic [6:0]        cur_pos;
    logic [6:0]        cur_goal;
    logic [7:0]        cur_mc;
    dir_t              cur_dir;
    logic [7:0]        trav_raw;
    logic [7:0]        trav;
    logic              imp;
    logic signed [4:0] plen;
    logic [6:0]        eff_next;
    logic              full;
    logic [6:0]        diff;
    logic [14:0]       prod1;
    logic [27:0]       m2;
    logic [8:0]        q_next;
    logic [7:0]        count;
    logic              go_up;
    logic              go_down;
    logic [7:0]        mc_dec;
    logic [14:0]       numer;
    logic [8:0]        rem_sh;
    logic              ge;
    logic [8:0]        rem_sub;
    logic [15:0]       up_sum;
    logic [6:0]        pos_new;
    logic signed [4:0] upc_dec;
    logic signed [4:0] dnc_dec;
    logic [7:0]        pres_inc;
    logic              step_hit;
    logic              end_rl;
    logic              emit_en;
    result_t           emit_res;

    assign idx      = ch_reg[IDX_W-1:0];
    assign ch_ok    = ({1'b0, ch_reg} < 4'(CHANNELS));
    assign cur_pos  = pos_reg[idx];
    assign cur_goal = goal_reg[idx];
    assign cur_mc   = mc_reg[idx];
    assign cur_dir  = dir_reg[idx];
    assign trav_raw = cfg.travel[{ch_reg, 3'b000} +: 8];
    assign trav     = (trav_raw == 8'd0) ? 8'd1 : trav_raw;
    assign imp      = cfg.impulse[ch_reg];
    assign plen     = (cfg.plen == 4'd0) ? 5'sd1 : $signed({1'b0, cfg.plen});

    always_comb
    begin
        case (cmd_reg)
            CMD_SET:    eff_next = (tgt_reg > FULL_POS) ? FULL_POS : tgt_reg;
            CMD_UP:     eff_next = 7'd0;
            CMD_DOWN:   eff_next = FULL_POS;
            CMD_INVERT: eff_next = (cur_pos != 7'd0) ? 7'd0 : FULL_POS;
            CMD_TOGGLE: eff_next = tog_reg[idx] ? FULL_POS : 7'd0;
            default:    eff_next = 7'd0;
        endcase
    end

    // Set-position count: |p - t| * travel / 100, or travel * 11 / 10 for end runs.
    assign full    = (eff_reg == 7'd0) || (eff_reg == FULL_POS);
    assign diff    = (cur_pos > eff_reg) ? (cur_pos - eff_reg) : (eff_reg - cur_pos);
    assign prod1   = 15'(full ? RUN_FACTOR : diff) * 15'(trav);
    assign m2      = 28'(prod_reg) * 28'(full ? RECIP_10 : RECIP_100);
    assign q_next  = full ? m2[SHIFT_10 +: 9] : m2[SHIFT_100 +: 9];
    assign count   = (q_reg > 9'd255) ? 8'd255 : q_reg[7:0];
    assign go_up   = (cur_pos > eff_reg) || (eff_reg == 7'd0);
    assign go_down = (cur_pos < eff_reg) || (eff_reg == FULL_POS);

    // Position estimate: remaining count * 100 / travel, one quotient bit a cycle.
    assign mc_dec  = cur_mc - 8'd1;
    assign numer   = 15'(mc_dec) * 15'(FULL_POS);
    assign rem_sh  = {rem_reg, num_reg[14]};
    assign ge      = (rem_sh >= {1'b0, trav});
    assign rem_sub = ge ? (rem_sh - {1'b0, trav}) : rem_sh;
    assign up_sum  = {1'b0, num_reg} + 16'(cur_goal);

    always_comb
    begin
        case (cur_dir)
            DIR_UP:   pos_new = (up_sum > 16'(FULL_POS)) ? FULL_POS : up_sum[6:0];
            DIR_DOWN: pos_new = (num_reg >= 15'(cur_goal)) ? 7'd0
                                : (cur_goal - num_reg[6:0]);
            default:  pos_new = cur_pos;
        endcase
    end

    assign upc_dec  = (upc_reg[idx] >= 5'sd0) ? (upc_reg[idx] - 5'sd1) : upc_reg[idx];
    assign dnc_dec  = (dnc_reg[idx] >= 5'sd0) ? (dnc_reg[idx] - 5'sd1) : dnc_reg[idx];
    assign pres_inc = (pres_reg == 8'd255) ? pres_reg : (pres_reg + 8'd1);
    assign step_hit = (pres_inc >= cfg.prescale);
    assign end_rl   = (cur_dir == DIR_DOWN);

    always_comb
    begin
        emit_en           = 1'b0;
        emit_res.kind     = KIND_RELAY;
        emit_res.unit     = ch_reg;
        emit_res.relay    = 1'b0;
        emit_res.drive_on = 1'b0;
        emit_res.pos      = 7'd0;
        case (op)
            OP_BUSY_ERR:
            begin
                emit_en       = 1'b1;
                emit_res.kind = KIND_BUSY;
            end
            OP_STOP:
            begin
                emit_en       = 1'b1;
                emit_res.kind = KIND_REPORT;
                emit_res.pos  = cur_pos;
            end
            OP_APPLY:
            begin
                emit_en           = go_up || go_down;
                emit_res.relay    = !go_up;
                emit_res.drive_on = 1'b1;
            end
            OP_REPORT:
            begin
                emit_en       = 1'b1;
                emit_res.kind = KIND_REPORT;
                emit_res.pos  = eff_reg;
            end
            OP_UPC:
            begin
                emit_en = (upc_dec == 5'sd0);
            end
            OP_DNC:
            begin
                emit_en        = (dnc_dec == 5'sd0);
                emit_res.relay = 1'b1;
            end
            OP_MOVE:
            begin
                emit_en           = (cur_mc == 8'd0) && (cur_dir != DIR_STILL);
                emit_res.relay    = end_rl;
                emit_res.drive_on = imp;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]  <= 7'd0;
                goal_reg[i] <= 7'd0;
                mc_reg[i]   <= 8'd0;
                dir_reg[i]  <= DIR_STILL;
                tog_reg[i]  <= 1'b0;
                upc_reg[i]  <= -5'sd1;
                dnc_reg[i]  <= -5'sd1;
            end
            pres_reg       <= 8'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            if (emit_en)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                pend_valid_reg <= 1'b1;
            end
            else if ((op == OP_FINISH) && pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            case (op)
                OP_DECODE:
                begin
                    if ((cmd_reg == CMD_TOGGLE) && ch_ok)
                    begin
                        tog_reg[idx] <= !tog_reg[idx];
                    end
                end
                OP_STOP:
                begin
                    mc_reg[idx]   <= 8'd0;
                    goal_reg[idx] <= cur_pos;
                end
                OP_APPLY:
                begin
                    if (go_up)
                    begin
                        mc_reg[idx]  <= (eff_reg == 7'd0) ? count : q_reg[7:0];
                        dir_reg[idx] <= DIR_UP;
                        if (imp)
                        begin
                            upc_reg[idx] <= plen;
                        end
                    end
                    else if (go_down)
                    begin
                        mc_reg[idx]  <= (eff_reg == FULL_POS) ? count : q_reg[7:0];
                        dir_reg[idx] <= DIR_DOWN;
                        if (imp)
                        begin
                            dnc_reg[idx] <= plen;
                        end
                    end
                end
                OP_REPORT:
                begin
                    goal_reg[idx] <= eff_reg;
                end
                OP_PRESCALE:
                begin
                    pres_reg <= step_hit ? 8'd0 : pres_inc;
                end
                OP_UPC:
                begin
                    upc_reg[idx] <= upc_dec;
                end
                OP_DNC:
                begin
                    dnc_reg[idx] <= dnc_dec;
                end
                OP_MOVE:
                begin
                    if (cur_mc != 8'd0)
                    begin
                        mc_reg[idx] <= mc_dec;
                    end
                    else
                    begin
                        if (cur_dir != DIR_STILL)
                        begin
                            dir_reg[idx] <= DIR_STILL;
                            if (imp && end_rl)
                            begin
                                dnc_reg[idx] <= plen;
                            end
                            else if (imp)
                            begin
                                upc_reg[idx] <= plen;
                            end
                        end
                        pos_reg[idx] <= cur_goal;
                    end
                end
                OP_POS:
                begin
                    pos_reg[idx] <= pos_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            pend_reg <= emit_res;
            out_reg  <= pend_reg;
        end
        else if (op == OP_FINISH)
        begin
            out_reg <= pend_reg;
        end
        case (op)
            OP_LATCH:
            begin
                cmd_reg <= command_in;
                ch_reg  <= channel_in;
                tgt_reg <= target_in;
            end
            OP_DECODE:
            begin
                eff_reg <= eff_next;
            end
            OP_MUL1:
            begin
                prod_reg <= prod1;
            end
            OP_MUL2:
            begin
                q_reg <= q_next;
            end
            OP_PRESCALE:
            begin
                ch_reg <= 3'd0;
            end
            OP_MOVE:
            begin
                num_reg  <= numer;
                rem_reg  <= 8'd0;
                dcnt_reg <= DIV_STEPS;
            end
            OP_DIV:
            begin
                num_reg  <= {num_reg[13:0], ge};
                rem_reg  <= rem_sub[7:0];
                dcnt_reg <= dcnt_reg - 4'd1;
            end
            OP_NEXT:
            begin
                ch_reg <= ch_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign status.is_tick  = (cmd_reg == CMD_TICK);
    assign status.cmd_ok   = ch_ok && (cmd_reg <= CMD_TOGGLE);
    assign status.moving   = (cur_dir != DIR_STILL);
    assign status.cmd_set  = (cmd_reg == CMD_SET);
    assign status.cmd_stop = (cmd_reg == CMD_STOP);
    assign status.step_hit = step_hit;
    assign status.mc_nz    = (cur_mc != 8'd0);
    assign status.div_last = (dcnt_reg == 4'd1);
    assign status.last_ch  = (ch_reg == 3'(CHANNELS - 1));

    assign res_valid = out_valid_reg;
    assign res_last  = out_last_reg;
    assign res       = out_reg;

endmodule

// File: sv/shutter_position_controller.sv
// ----------------------------------------------------------------------------
// Shutter position controller
// Multi-channel roller-shutter controller with travel-time position estimate.
// ----------------------------------------------------------------------------
// A tick that does not complete a prescale period only updates the prescaler; one
// that does walks all channels and runs the serial divider on each channel whose
// run count is not yet zero. One item at a time: busy falls as the item's last
// result is registered. Results are strobed for one cycle and cannot be stalled.
// rst_n clears the channel state, the prescaler, the configuration and the result
// flags; the command and result data registers are not reset.
// ----------------------------------------------------------------------------
module shutter_position_controller
    import spc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [2:0]  channel,
    input  logic [6:0]  target_position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic        valid,
    output logic [1:0]  kind,
    output logic [2:0]  unit,
    output logic        relay,
    output logic        drive_on,
    output logic [6:0]  reported_position,
    output logic        last
);

    // Configuration registers sit at 8-byte strides since the travel table is
    // 64 bits wide; the register number is taken from paddr[4:3].
    logic [63:0] travel_reg;
    logic [7:0]  impulse_reg;
    logic [7:0]  prescale_reg;
    logic [3:0]  plen_reg;
    reg_idx_t    reg_sel;
    logic        wr_en;
    cfg_t        cfg;
    op_t         op;
    status_t     status;
    logic        res_valid;
    logic        res_last;
    result_t     res;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg   <= 64'd0;
            impulse_reg  <= 8'd0;
            prescale_reg <= PRESCALE_RESET;
            plen_reg     <= PULSE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_TRAVEL:   travel_reg   <= pwdata;
                REG_IMPULSE:  impulse_reg  <= pwdata[7:0];
                REG_PRESCALE: prescale_reg <= pwdata[7:0];
                REG_PULSE:    plen_reg     <= pwdata[3:0];
                default:      travel_reg   <= travel_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TRAVEL:   prdata = travel_reg;
            REG_IMPULSE:  prdata = {56'd0, impulse_reg};
            REG_PRESCALE: prdata = {56'd0, prescale_reg};
            REG_PULSE:    prdata = {60'd0, plen_reg};
            default:      prdata = 64'd0;
        endcase
    end

    assign cfg.travel   = travel_reg;
    assign cfg.impulse  = impulse_reg;
    assign cfg.prescale = prescale_reg;
    assign cfg.plen     = plen_reg;

    // The sequencer issues one datapath operation per cycle and follows the
    // datapath's status to pick the path for each item.
    spc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    // Each result is held one step in the datapath so that the final result
    // of an item can be marked when the item completes.
    spc_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .command_in (command),
        .channel_in (channel),
        .target_in  (target_position),
        .cfg        (cfg),
        .status     (status),
        .res_valid  (res_valid),
        .res_last   (res_last),
        .res        (res)
    );

    assign valid             = res_valid;
    assign last              = res_last;
    assign kind              = res.kind;
    assign unit              = res.unit;
    assign relay             = res.relay;
    assign drive_on          = res.drive_on;
    assign reported_position = res.pos;

    // An accepted item always keeps the block busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

    // A result that is not the last of its item only appears while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
    else $error("intermediate result outside an item");

    // Reported positions stay within the saturated range.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (reported_position <= FULL_POS))
    else $error("reported position out of range");

endmodule

// File: test/spc_checker.sv
// ----------------------------------------------------------------------------
// Shutter position controller checker
// Snoops the command, configuration and result ports. It keeps its own model
// of every channel and compares each result strobe, field by field, with
// the oldest expected result.
// ----------------------------------------------------------------------------
module spc_checker
    import spc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  command,
    input  logic [2:0]  channel,
    input  logic [6:0]  target_position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        valid,
    input  logic [1:0]  kind,
    input  logic [2:0]  unit,
    input  logic        relay,
    input  logic        drive_on,
    input  logic [6:0]  reported_position,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        kind_t      kind;
        logic [2:0] unit;
        logic       relay;
        logic       drive_on;
        logic [6:0] pos;
        logic       last;
    } shutter_res_t;

    shutter_res_t expected_results[$];
    shutter_res_t item_results[$];

    // Configuration copy.
    logic [63:0] travel_tab;
    logic [7:0]  impulse_mask;
    logic [7:0]  prescale;
    logic [3:0]  plen;

    // Channel state copy.
    logic [6:0]  pos_est [8];
    logic [6:0]  goal [8];
    logic [7:0]  run_left [8];
    dir_t        dir [8];
    logic        toggle [8];
    int          up_pulse [8];
    int          dn_pulse [8];
    logic [7:0]  tick_count;

    assign pending = expected_results.size();

    function automatic int travel_of(int ch);
        int t;
        t = int'(travel_tab[8*ch +: 8]);
        return (t == 0) ? 1 : t;
    endfunction

    function automatic int pulse_of();
        return (plen == 4'd0) ? 1 : int'(plen);
    endfunction

    function automatic int end_run(int ch);
        int c;
        c = travel_of(ch) * 11 / 10;
        return (c > 255) ? 255 : c;
    endfunction

    function automatic void add_result(kind_t k, int ch, logic rl, logic on, int p);
        shutter_res_t r;
        if (item_results.size() >= 24)
            return;
        r.kind = k;
        r.unit = ch[2:0];
        r.relay = rl;
        r.drive_on = on;
        r.pos = p[6:0];
        r.last = 1'b0;
        item_results.push_back(r);
    endfunction

    function automatic void goto_position(int ch, int tgt);
        int p;
        int t;
        p = int'(pos_est[ch]);
        t = travel_of(ch);
        if (tgt > 100)
            tgt = 100;
        if (dir[ch] != DIR_STILL) begin
            add_result(KIND_BUSY, ch, 1'b0, 1'b0, 0);
            return;
        end
        if (p > tgt || tgt == 0) begin
            run_left[ch] = (tgt == 0) ? 8'(end_run(ch)) : 8'((p - tgt) * t / 100);
            dir[ch] = DIR_UP;
            if (impulse_mask[ch])
                up_pulse[ch] = pulse_of();
            add_result(KIND_RELAY, ch, 1'b0, 1'b1, 0);
        end
        if (p < tgt || tgt == 100) begin
            run_left[ch] = (tgt == 100) ? 8'(end_run(ch)) : 8'((tgt - p) * t / 100);
            dir[ch] = DIR_DOWN;
            if (impulse_mask[ch])
                dn_pulse[ch] = pulse_of();
            add_result(KIND_RELAY, ch, 1'b1, 1'b1, 0);
        end
        goal[ch] = tgt[6:0];
        add_result(KIND_REPORT, ch, 1'b0, 1'b0, tgt);
    endfunction

    function automatic void halt_channel(int ch);
        run_left[ch] = 8'd0;
        goal[ch] = pos_est[ch];
        add_result(KIND_REPORT, ch, 1'b0, 1'b0, int'(pos_est[ch]));
    endfunction

    function automatic void run_to_end(int ch, int tgt);
        if (dir[ch] != DIR_STILL)
            halt_channel(ch);
        else
            goto_position(ch, tgt);
    endfunction

    // One control step of one channel: pulse timers, position estimate, and
    // the end of a move.
    function automatic void control_step(int ch);
        int d;
        int v;
        logic rl;
        if (up_pulse[ch] >= 0)
            up_pulse[ch]--;
        if (up_pulse[ch] == 0)
            add_result(KIND_RELAY, ch, 1'b0, 1'b0, 0);
        if (dn_pulse[ch] >= 0)
            dn_pulse[ch]--;
        if (dn_pulse[ch] == 0)
            add_result(KIND_RELAY, ch, 1'b1, 1'b0, 0);
        if (run_left[ch] > 0) begin
            run_left[ch]--;
            d = int'(run_left[ch]) * 100 / travel_of(ch);
            if (dir[ch] == DIR_UP) begin
                v = d + int'(goal[ch]);
                pos_est[ch] = (v > 100) ? 7'd100 : v[6:0];
            end
            else if (dir[ch] == DIR_DOWN) begin
                v = int'(goal[ch]) - d;
                pos_est[ch] = (d >= int'(goal[ch])) ? 7'd0 : v[6:0];
            end
        end
        else begin
            rl = (dir[ch] == DIR_DOWN);
            if (dir[ch] != DIR_STILL) begin
                dir[ch] = DIR_STILL;
                if (impulse_mask[ch]) begin
                    if (rl)
                        dn_pulse[ch] = pulse_of();
                    else
                        up_pulse[ch] = pulse_of();
                    add_result(KIND_RELAY, ch, rl, 1'b1, 0);
                end
                else begin
                    add_result(KIND_RELAY, ch, rl, 1'b0, 0);
                end
            end
            pos_est[ch] = goal[ch];
        end
    endfunction

    function automatic void predict_item(logic [2:0] cmd, logic [2:0] ch, logic [6:0] tgt);
        int c;
        c = int'(ch);
        item_results.delete();
        if (cmd == CMD_TICK) begin
            if (tick_count < 8'd255)
                tick_count++;
            if (tick_count >= prescale) begin
                tick_count = 8'd0;
                for (int i = 0; i < 8; i++)
                    control_step(i);
            end
        end
        else begin
            case (cmd)
                CMD_SET:    goto_position(c, int'(tgt));
                CMD_UP:     run_to_end(c, 0);
                CMD_DOWN:   run_to_end(c, 100);
                CMD_STOP:   halt_channel(c);
                CMD_INVERT: begin
                    if (dir[c] != DIR_STILL)
                        halt_channel(c);
                    else
                        goto_position(c, (pos_est[c] > 0) ? 0 : 100);
                end
                CMD_TOGGLE: begin
                    run_to_end(c, toggle[c] ? 100 : 0);
                    toggle[c] = ~toggle[c];
                end
                default: ;
            endcase
        end
        if (item_results.size() > 0)
            item_results[item_results.size() - 1].last = 1'b1;
        foreach (item_results[i])
            expected_results.push_back(item_results[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        shutter_res_t e;
        logic bad;
        if (!rst_n) begin
            travel_tab = '0;
            impulse_mask = '0;
            prescale = PRESCALE_RESET;
            plen = PULSE_RESET;
            tick_count = '0;
            for (int i = 0; i < 8; i++) begin
                pos_est[i] = '0;
                goal[i] = '0;
                run_left[i] = '0;
                dir[i] = DIR_STILL;
                toggle[i] = 1'b0;
                up_pulse[i] = -1;
                dn_pulse[i] = -1;
            end
            expected_results.delete();
            fail_count <= 0;
        end
        else begin
            // Results are checked before a new item is predicted, so a result
            // on the edge that accepts the next item is matched correctly.
            if (valid) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result kind=%0d unit=%0d", kind, unit);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_results.pop_front();
                    bad = (kind != e.kind) || (unit != e.unit) || (relay != e.relay) ||
                          (drive_on != e.drive_on) || (reported_position != e.pos) ||
                          (last != e.last);
                    if (bad) begin
                        if (fail_count < 10)
                            $display("ERROR: expected k%0d u%0d r%0d o%0d p%0d l%0d, got k%0d u%0d r%0d o%0d p%0d l%0d",
                                     e.kind, e.unit, e.relay, e.drive_on, e.pos, e.last,
                                     kind, unit, relay, drive_on, reported_position, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_TRAVEL:   travel_tab = pwdata;
                    REG_IMPULSE:  impulse_mask = pwdata[7:0];
                    REG_PRESCALE: prescale = pwdata[7:0];
                    REG_PULSE:    plen = pwdata[3:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_item(command, channel, target_position);
        end
    end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Shutter position controller testbench
// Drives directed and random command items through several register settings
// and lets the checker compare every result strobe with its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import spc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [2:0]  channel;
    logic [6:0]  target_position;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        valid;
    logic [1:0]  kind;
    logic [2:0]  unit;
    logic        relay;
    logic        drive_on;
    logic [6:0]  reported_position;
    logic        last;
    int          fail_count;
    int          pending;

    // Items numbered 40 to 74 are sent back to back, so the block
    // also sees a long run of commands with no gaps at all.
    int          item_no;

    shutter_position_controller dut (.*);

    spc_checker checker_i (.*);

    // The clock has a period of 4 time units.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // A register write is a setup phase followed by an access phase. The
    // register index picks an 8-byte slot because the travel table is 64 bits.
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sends one item. Inputs change on the falling edge. Since busy only
    // changes on a rising edge, its value at the falling edge tells whether
    // the next rising edge accepts the item. Start stays high between
    // back-to-back items.
    task automatic send_item(logic [2:0] cmd, logic [2:0] ch, logic [6:0] tgt);
        logic taken;
        @(negedge clk);
        if (!(item_no >= 40 && item_no < 75)) begin
            while ($urandom_range(99) < 36) begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        command <= cmd;
        channel <= ch;
        target_position <= tgt;
        taken = 1'b0;
        while (!taken) begin
            #1;
            taken = !busy;
            @(posedge clk);
            if (!taken)
                @(negedge clk);
        end
        item_no++;
    endtask

    // Lowers start and waits until every expected result has arrived and busy
    // is low, so a tick that produced no result has also walked all channels.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // Random items favour ticks so moves progress, and the lower channels so
    // that commands often land on a shutter that is already moving.
    task automatic random_items(int count);
        logic [2:0] cmd;
        logic [2:0] ch;
        logic [6:0] tgt;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 50)
                cmd = CMD_TICK;
            else if (r < 53)
                cmd = 3'd7;
            else
                cmd = 3'($urandom_range(6, 1));
            ch = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
            r = $urandom_range(9);
            tgt = (r == 0) ? 7'd0 : (r == 1) ? 7'd100 : 7'($urandom_range(127));
            send_item(cmd, ch, tgt);
        end
    endtask

    task automatic random_travel(output logic [63:0] tab);
        for (int c = 0; c < 8; c++)
            tab[8*c +: 8] = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(20, 1));
    endtask

    initial
    begin
        logic [63:0] tab;
        rst_n = 1'b0;
        start = 1'b0;
        command = 3'd0;
        channel = 3'd0;
        target_position = 7'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_no = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: prescale of 20 and a travel time of zero everywhere.
        random_items(15);
        drain();

        // Travel times mostly short, a prescale of one, impulses on channels 2 and 3.
        write_reg(REG_TRAVEL, {8'd3, 8'd7, 8'd255, 8'd231, 8'd5, 8'd4, 8'd10, 8'd0});
        write_reg(REG_IMPULSE, 64'h0C);
        write_reg(REG_PRESCALE, 64'd1);
        write_reg(REG_PULSE, 64'd2);

        // Directed part: moves, a command while moving turning into a stop,
        // the busy refusal, a target equal to the position, a stop while
        // still, invert, toggle, a zero travel time, a target above 100, the
        // saturated end run and an unknown command.
        send_item(CMD_SET, 3'd1, 7'd60);
        send_item(CMD_UP, 3'd1, 7'd0);
        send_item(CMD_SET, 3'd1, 7'd30);
        send_item(CMD_TICK, 3'd0, 7'd0);
        send_item(CMD_SET, 3'd1, 7'd30);
        repeat (4) send_item(CMD_TICK, 3'd0, 7'd0);
        send_item(CMD_SET, 3'd1, 7'd30);
        send_item(CMD_STOP, 3'd1, 7'd0);
        send_item(CMD_INVERT, 3'd2, 7'd0);
        send_item(CMD_TOGGLE, 3'd3, 7'd0);
        send_item(CMD_TOGGLE, 3'd3, 7'd0);
        send_item(CMD_DOWN, 3'd0, 7'd0);
        send_item(CMD_SET, 3'd4, 7'd127);
        send_item(CMD_DOWN, 3'd5, 7'd0);
        send_item(3'd7, 3'd7, 7'd127);
        send_item(CMD_SET, 3'd7, 7'd100);
        repeat (5) send_item(CMD_TICK, 3'd0, 7'd0);
        send_item(CMD_STOP, 3'd5, 7'd0);
        send_item(CMD_STOP, 3'd4, 7'd0);
        random_items(25);
        drain();

        // Zero prescale and zero pulse length, every channel in impulse mode.
        random_travel(tab);
        write_reg(REG_TRAVEL, tab);
        write_reg(REG_IMPULSE, 64'hFF);
        write_reg(REG_PRESCALE, 64'd0);
        write_reg(REG_PULSE, 64'd0);
        random_items(25);
        drain();

        // Extremes: longest travel times, largest prescale and pulse length.
        write_reg(REG_TRAVEL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_IMPULSE, 64'hAA);
        write_reg(REG_PRESCALE, 64'd255);
        write_reg(REG_PULSE, 64'd15);
        random_items(10);
        drain();

        // Mixed settings with the other half of the channels pulsed.
        random_travel(tab);
        write_reg(REG_TRAVEL, tab);
        write_reg(REG_IMPULSE, 64'h55);
        write_reg(REG_PRESCALE, 64'd2);
        write_reg(REG_PULSE, 64'd15);
        random_items(29);
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/spc_pkg.sv
sv/spc_ctrl.sv
sv/spc_datapath.sv
sv/shutter_position_controller.sv
test/spc_checker.sv
test/tb_top.sv
